>>> src/ncps_pkg.sv
// shared types and constants for the nearest color pixel search
// no dependencies
package ncps_pkg;

  localparam int PixelW  = 32;
  localparam int ColorW  = 24;
  localparam int ChanW   = 8;
  localparam int CoordW  = 8;
  localparam int DistW   = 18;
  localparam int ManW    = 9;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 24;

  localparam logic [DistW-1:0] DistInit = '1;
  localparam logic [ManW-1:0]  ManInit  = '1;
  localparam logic [DistW-1:0] DistMax  = 18'd195075;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TARGET_COLOR = 2'd0,
    CFG_CURSOR_COL   = 2'd1,
    CFG_CURSOR_ROW   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [DistW-1:0]  color_dist;
    logic [ManW-1:0]   man;
  } cand_t;

  typedef struct packed {
    logic fire;
    logic first;
    logic last;
  } stage_ctl_t;

endpackage

>>> src/ncps_pos.sv
// raster column and row counters for incoming pixels
// depends on ncps_pkg
module ncps_pos import ncps_pkg::*; #(
  parameter int CANVAS_WIDTH  = 256,
  parameter int CANVAS_HEIGHT = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stage_ctl_t        ctl_i,
  output logic [CoordW-1:0] col_o,
  output logic [CoordW-1:0] row_o
);

  localparam int ColLimit = (CANVAS_WIDTH > 256) ? 256 : CANVAS_WIDTH;
  localparam int RowLimit = (CANVAS_HEIGHT > 256) ? 256 : CANVAS_HEIGHT;

  logic [CoordW-1:0] col_q, col_d;
  logic [CoordW-1:0] row_q, row_d;
  logic [CoordW:0]   col_inc;
  logic [CoordW:0]   row_inc;

  assign col_o   = ctl_i.first ? '0 : col_q;
  assign row_o   = ctl_i.first ? '0 : row_q;
  assign col_inc = {1'b0, col_o} + 1'b1;
  assign row_inc = {1'b0, row_o} + 1'b1;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (ctl_i.fire) begin
      if (ctl_i.last) begin
        col_d = '0;
        row_d = '0;
      end else if (col_inc >= (CoordW+1)'(ColLimit)) begin
        col_d = '0;
        row_d = (row_inc >= (CoordW+1)'(RowLimit)) ? '0 : row_inc[CoordW-1:0];
      end else begin
        col_d = col_inc[CoordW-1:0];
        row_d = row_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

>>> src/ncps_dist.sv
// squared color distance and manhattan distance to the cursor
// depends on ncps_pkg
module ncps_dist import ncps_pkg::*; (
  input  rgb_t              pix_i,
  input  rgb_t              target_i,
  input  logic [CoordW-1:0] col_i,
  input  logic [CoordW-1:0] row_i,
  input  logic [CoordW-1:0] cursor_col_i,
  input  logic [CoordW-1:0] cursor_row_i,
  output logic [DistW-1:0]  dist_o,
  output logic [ManW-1:0]   man_o
);

  logic [ChanW-1:0]   dr, dg, db;
  logic [2*ChanW-1:0] sr, sg, sb;
  logic [CoordW-1:0]  dc, dw;

  assign dr = (pix_i.red > target_i.red) ? pix_i.red - target_i.red
                                         : target_i.red - pix_i.red;
  assign dg = (pix_i.green > target_i.green) ? pix_i.green - target_i.green
                                             : target_i.green - pix_i.green;
  assign db = (pix_i.blue > target_i.blue) ? pix_i.blue - target_i.blue
                                           : target_i.blue - pix_i.blue;
  assign sr = dr * dr;
  assign sg = dg * dg;
  assign sb = db * db;
  assign dist_o = DistW'(sr) + DistW'(sg) + DistW'(sb);

  assign dc = (col_i > cursor_col_i) ? col_i - cursor_col_i : cursor_col_i - col_i;
  assign dw = (row_i > cursor_row_i) ? row_i - cursor_row_i : cursor_row_i - row_i;
  assign man_o = ManW'(dc) + ManW'(dw);

endmodule

>>> src/ncps_best.sv
// best candidate register with distance and tie-break compare
// depends on ncps_pkg
module ncps_best import ncps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  stage_ctl_t ctl_i,
  input  cand_t      cand_i,
  output cand_t      sel_o
);

  cand_t best_q, best_d;
  logic  take;

  assign take = ctl_i.first || (cand_i.color_dist < best_q.color_dist) ||
                ((cand_i.color_dist == best_q.color_dist) && (cand_i.man < best_q.man));
  assign sel_o = take ? cand_i : best_q;

  always_comb begin
    best_d = best_q;
    if (ctl_i.fire) begin
      if (ctl_i.last) begin
        best_d = '{col: '0, row: '0, color_dist: DistInit, man: ManInit};
      end else begin
        best_d = sel_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '{col: '0, row: '0, color_dist: DistInit, man: ManInit};
    end else begin
      best_q <= best_d;
    end
  end

endmodule

>>> src/nearest_color_pixel_search.sv
// Nearest color pixel search: takes one pixel per cycle in raster order and
// reports, on the pixel marked last, the position and squared RGB distance of
// the pixel closest to target_color (ties go to the smaller manhattan distance
// to the cursor, then to the earlier pixel). An item passes an input register
// and a result register before out_valid_o rises; it takes a pixel every
// cycle and stalls only while a last pixel waits on a held result register.
// depends on ncps_pkg, ncps_pos, ncps_dist, ncps_best
module nearest_color_pixel_search import ncps_pkg::*; #(
  parameter int CANVAS_WIDTH  = 256,
  parameter int CANVAS_HEIGHT = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [PixelW-1:0]   pixel_i,
  input  logic                first_i,
  input  logic                last_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CoordW-1:0]   best_col_o,
  output logic [CoordW-1:0]   best_row_o,
  output logic [DistW-1:0]    best_color_distance_o
);

  rgb_t              target_q;
  logic [CoordW-1:0] cursor_col_q, cursor_row_q;

  logic              s1_valid_q;
  rgb_t              s1_pix_q;
  logic              s1_first_q, s1_last_q;
  logic [CoordW-1:0] s1_col_q, s1_row_q;

  logic              out_valid_q;
  cand_t             out_q;

  logic              in_fire, s1_fire, out_free;
  stage_ctl_t        in_ctl, s1_ctl;
  logic [CoordW-1:0] in_col, in_row;
  cand_t             cand, sel;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q     <= '0;
      cursor_col_q <= '0;
      cursor_row_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TARGET_COLOR: target_q     <= rgb_t'(cfg_data_i[ColorW-1:0]);
        CFG_CURSOR_COL:   cursor_col_q <= cfg_data_i[CoordW-1:0];
        CFG_CURSOR_ROW:   cursor_row_q <= cfg_data_i[CoordW-1:0];
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && (!s1_last_q || out_free);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign in_ctl = '{fire: in_fire, first: first_i, last: last_i};
  assign s1_ctl = '{fire: s1_fire, first: s1_first_q, last: s1_last_q};

  ncps_pos #(
    .CANVAS_WIDTH (CANVAS_WIDTH),
    .CANVAS_HEIGHT(CANVAS_HEIGHT)
  ) u_pos (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (in_ctl),
    .col_o (in_col),
    .row_o (in_row)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q   <= rgb_t'(pixel_i[PixelW-1:PixelW-ColorW]);
      s1_first_q <= first_i;
      s1_last_q  <= last_i;
      s1_col_q   <= in_col;
      s1_row_q   <= in_row;
    end
  end

  assign cand.col = s1_col_q;
  assign cand.row = s1_row_q;

  ncps_dist u_dist (
    .pix_i       (s1_pix_q),
    .target_i    (target_q),
    .col_i       (s1_col_q),
    .row_i       (s1_row_q),
    .cursor_col_i(cursor_col_q),
    .cursor_row_i(cursor_row_q),
    .dist_o      (cand.color_dist),
    .man_o       (cand.man)
  );

  ncps_best u_best (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (s1_ctl),
    .cand_i(cand),
    .sel_o (sel)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_q) begin
      out_q <= sel;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign best_col_o            = out_q.col;
  assign best_row_o            = out_q.row;
  assign best_color_distance_o = out_q.color_dist;

`ifndef NO_ASSERTIONS
  a_last_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_last_q |=> out_valid_o)
    else $error("last pixel did not produce a result");

  a_blocked_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_last_q && out_valid_q && out_stall_i |-> in_stall_o)
    else $error("input not stalled while result register is held");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s1_last_q)
    else $error("input stalled without a waiting last pixel");

  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> best_color_distance_o <= DistMax)
    else $error("reported color distance out of range");
`endif

endmodule
